@@ hw/rtl/html_entity_escaper_core_macros.svh @@
// ---------------------------------------------------------------------------
// html entity escaper assertion macros
// clocked property checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef HTML_ENTITY_ESCAPER_CORE_MACROS_SVH
`define HTML_ENTITY_ESCAPER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define HEE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be true outside reset
`define HEE_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define HEE_ASSERT(lbl, clk, rstn, prop, msg)

`define HEE_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ hw/rtl/hee_pkg.sv @@
// ---------------------------------------------------------------------------
// hee_pkg
// shared types, character codes and run tables of the html entity escaper
// ---------------------------------------------------------------------------
package hee_pkg;

    localparam int OUT_BUFFER_SIZE = 16384;
    localparam logic [15:0] LIMIT_RESET = 16'(OUT_BUFFER_SIZE - 2);
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam int QUEUE_DEPTH_DEF = 4;

    // longest expansion is ten bytes
    localparam int RUN_IDX_W = 4;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    localparam logic [0:4][7:0] AMP_RUN  = "&amp;";
    localparam logic [0:3][7:0] LT_RUN   = "&lt;";
    localparam logic [0:3][7:0] GT_RUN   = "&gt;";
    localparam logic [0:6][7:0] QUOT_RUN = "&ldquo;";
    localparam logic [0:9][7:0] LF_RUN   = "<BR><BR />";

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_AMP,
        KIND_LT,
        KIND_GT,
        KIND_QUOT,
        KIND_LF,
        KIND_MARKER
    } kind_t;

    // one classified item waiting for expansion
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } desc_t;

    function automatic logic [RUN_IDX_W-1:0] run_len(input kind_t kind);
        logic [RUN_IDX_W-1:0] len;
        len = RUN_IDX_W'(1);
        unique case (kind)
            KIND_AMP:  len = RUN_IDX_W'(5);
            KIND_LT:   len = RUN_IDX_W'(4);
            KIND_GT:   len = RUN_IDX_W'(4);
            KIND_QUOT: len = RUN_IDX_W'(7);
            KIND_LF:   len = RUN_IDX_W'(10);
            default:   len = RUN_IDX_W'(1);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] run_char(input desc_t d, input logic [RUN_IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        if (idx < run_len(d.kind))
        begin
            unique case (d.kind)
                KIND_PLAIN:  ch = d.data;
                KIND_AMP:    ch = AMP_RUN[idx[2:0]];
                KIND_LT:     ch = LT_RUN[idx[1:0]];
                KIND_GT:     ch = GT_RUN[idx[1:0]];
                KIND_QUOT:   ch = QUOT_RUN[idx[2:0]];
                KIND_LF:     ch = LF_RUN[idx];
                default:     ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/hee_front.sv @@
// ---------------------------------------------------------------------------
// hee_front
// accepts input items, classifies them and keeps the per-string output count
// ---------------------------------------------------------------------------
module hee_front
    import hee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        q_full,
    output logic        q_push,
    output desc_t       q_desc
);

    logic [15:0] limit_reg;
    logic [15:0] count_reg, count_next;
    logic        reached_reg, reached_next;

    kind_t       kind;
    logic [16:0] sum;
    logic [15:0] sat;
    logic        hit;
    logic        emit;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        unique case (in_byte)
            CH_AMP:  kind = KIND_AMP;
            CH_LT:   kind = KIND_LT;
            CH_GT:   kind = KIND_GT;
            CH_QUOT: kind = KIND_QUOT;
            CH_LF:   kind = KIND_LF;
            default: kind = KIND_PLAIN;
        endcase
    end

    assign sum = {1'b0, count_reg} + {{(17 - RUN_IDX_W){1'b0}}, run_len(kind)};
    assign sat = sum[16] ? COUNT_MAX : sum[15:0];
    assign hit = sat >= limit_reg;

    always_comb
    begin
        emit         = 1'b0;
        q_desc.kind  = kind;
        q_desc.data  = in_byte;
        q_desc.last  = in_last;
        q_desc.trunc = 1'b0;
        count_next   = count_reg;
        reached_next = reached_reg;
        if (accept)
        begin
            if (in_byte == CH_NUL)
            begin
                // bare end marker closes the string
                emit         = 1'b1;
                q_desc.kind  = KIND_MARKER;
                q_desc.last  = 1'b1;
                q_desc.trunc = reached_reg;
                count_next   = '0;
                reached_next = 1'b0;
            end
            else if (reached_reg)
            begin
                // string already cut: drop, unless it ends here
                emit         = in_last;
                q_desc.kind  = KIND_MARKER;
                q_desc.last  = 1'b1;
                q_desc.trunc = 1'b1;
                if (in_last)
                begin
                    count_next   = '0;
                    reached_next = 1'b0;
                end
            end
            else
            begin
                emit         = 1'b1;
                q_desc.trunc = hit;
                count_next   = in_last ? '0 : sat;
                reached_next = in_last ? 1'b0 : hit;
            end
        end
    end

    assign q_push = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            count_reg   <= '0;
            reached_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            count_reg   <= count_next;
            reached_reg <= reached_next;
        end
    end

endmodule

@@ hw/rtl/hee_queue.sv @@
// ---------------------------------------------------------------------------
// hee_queue
// short descriptor queue between the classifier and the expander
// ---------------------------------------------------------------------------
`include "html_entity_escaper_core_macros.svh"

module hee_queue
    import hee_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t wr_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t              slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `HEE_NEVER(a_no_push_full, clk, rst_n, push && full, "push into full queue")
    `HEE_NEVER(a_no_pop_empty, clk, rst_n, pop && !head_valid, "pop from empty queue")
    `HEE_ASSERT(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overrun")
    `HEE_ASSERT(a_ptr_match, clk, rst_n,
        (wr_ptr_reg != rd_ptr_reg) || (count_reg == '0) || full, "pointers disagree with count")

endmodule

@@ hw/rtl/hee_back.sv @@
// ---------------------------------------------------------------------------
// hee_back
// expands queued descriptors into escaped output bytes, one per cycle while out_ready is high
// ---------------------------------------------------------------------------
`include "html_entity_escaper_core_macros.svh"

module hee_back
    import hee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  desc_t       head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        string_end,
    output logic        truncated
);

    logic [RUN_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_bvalid_reg;
    logic                 out_rlast_reg;
    logic                 out_send_reg;
    logic                 out_trunc_reg;

    logic                 advance;
    logic                 at_end;

    // output register frees up when empty or taken this cycle
    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign at_end  = idx_reg == run_len(head.kind) - RUN_IDX_W'(1);
    assign pop     = advance && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_end ? '0 : idx_reg + RUN_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= run_char(head, idx_reg);
            out_bvalid_reg <= head.kind != KIND_MARKER;
            out_rlast_reg  <= at_end;
            out_send_reg   <= at_end && head.last;
            out_trunc_reg  <= head.trunc;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = out_bvalid_reg;
    assign run_last   = out_rlast_reg;
    assign string_end = out_send_reg;
    assign truncated  = out_trunc_reg;

    `HEE_ASSERT(a_idx_in_run, clk, rst_n,
        head_valid |-> (idx_reg < run_len(head.kind)), "run index past end of run")
    `HEE_ASSERT(a_idx_idle, clk, rst_n, !head_valid |-> (idx_reg == '0), "run index left over")
    `HEE_ASSERT(a_marker_closes, clk, rst_n,
        (out_valid_reg && !out_bvalid_reg) |-> (out_rlast_reg && out_send_reg),
        "end marker not closing its string")

endmodule

@@ hw/rtl/html_entity_escaper_core.sv @@
// ---------------------------------------------------------------------------
// html_entity_escaper_core
// escapes a byte stream into html text with a per-string output limit
// ---------------------------------------------------------------------------
//  channel   dir  tdata                          tlast        tuser
//  s_*       in   in_byte[7:0]                   string_last  -
//  m_*       out  out_byte[7:0], run_last, pad   string_end   byte_valid, truncated
//  cfg_*     in   output_limit[15:0] (cfg_wdata) -            -
//
//  ordinary bytes: one item in and one item out per cycle while m_tready is high
//  an expansion holds the expander until every byte of its run is out, the
//  queue of QUEUE_DEPTH descriptors lets input keep flowing meanwhile
//  a taken item is written to the queue, then its first result is registered onto m_*
//  reset clears the string count, the cut flag, the queue and the output stage
//  m_tready low stalls the expander only; input stops once the queue fills
// ---------------------------------------------------------------------------
module html_entity_escaper_core
    import hee_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // output_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // out_byte[7:0], run_last, zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser        // byte_valid, truncated
);

    desc_t q_desc;
    desc_t head;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  head_valid;
    logic  out_run_last;
    logic  out_bvalid;
    logic  out_trunc;
    logic [7:0] out_byte;

    hee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_desc)
    );

    hee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_desc    (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    hee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .byte_valid (out_bvalid),
        .run_last   (out_run_last),
        .string_end (m_tlast),
        .truncated  (out_trunc)
    );

    assign m_tdata = {7'b0, out_run_last, out_byte};
    assign m_tuser = {out_trunc, out_bvalid};

endmodule

@@ verif/html_entity_escaper_core_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// html_entity_escaper_core_test
// self-checking bench for the html entity escaper: a directed table, then random
// strings under a series of output limits, with random idle and stall on both
// streams; an output item is compared with its typed row or a built-in predictor
// ---------------------------------------------------------------------------
module html_entity_escaper_core_test
    import hee_pkg::*;
();

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 410;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_PCT     = 25;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
        logic       truncated;
    } esc_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] value;
        logic        is_last;
        logic        typed;
        esc_result_t want;
    } row_t;

    localparam esc_result_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // escaper state as the predictor sees it
    logic [15:0] limit_model = LIMIT_RESET;
    logic [15:0] count_model = '0;
    logic        cut_model = 1'b0;

    esc_result_t pending_results [$];
    logic        row_typed = 1'b0;
    esc_result_t row_want = NO_RESULT;
    int          in_idle_pct = IDLE_PCT;
    int          out_stall_pct = IDLE_PCT;
    int          fail_count = 0;
    int          cycle_count = 0;
    row_t        steps [0:26];

    html_entity_escaper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // expands one accepted character into the output items it should cause
    function automatic void escape_char(input logic [7:0] ch, input logic is_last);
        logic [79:0] run_str;
        int          len;
        logic [16:0] sum;
        esc_result_t r;
        if (ch == CH_NUL)
        begin
            pending_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1, cut_model});
            count_model = '0;
            cut_model = 1'b0;
            return;
        end
        if (cut_model)
        begin
            // string already cut: only a closing item gives a bare end marker
            if (is_last)
            begin
                pending_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 1'b1});
                count_model = '0;
                cut_model = 1'b0;
            end
            return;
        end
        run_str = {72'd0, ch};
        len = 1;
        case (ch)
            CH_AMP:  begin run_str = "&amp;";      len = 5;  end
            CH_LT:   begin run_str = "&lt;";       len = 4;  end
            CH_GT:   begin run_str = "&gt;";       len = 4;  end
            CH_QUOT: begin run_str = "&ldquo;";    len = 7;  end
            CH_LF:   begin run_str = "<BR><BR />"; len = 10; end
            default: ;
        endcase
        sum = {1'b0, count_model} + 17'(len);
        count_model = sum[16] ? COUNT_MAX : sum[15:0];
        if (count_model >= limit_model)
            cut_model = 1'b1;
        for (int k = 0; k < len; k++)
        begin
            // literal is right-aligned, first character in the highest used byte
            r.out_byte   = run_str[8 * (len - 1 - k) +: 8];
            r.byte_valid = 1'b1;
            r.run_last   = (k == len - 1);
            r.string_end = is_last && (k == len - 1);
            r.truncated  = cut_model;
            pending_results.push_back(r);
        end
        if (is_last)
        begin
            count_model = '0;
            cut_model = 1'b0;
        end
    endfunction

    // input acceptance and output checking share one process, in a fixed order
    always @(posedge clk)
    begin
        int          depth;
        esc_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                depth = pending_results.size();
                escape_char(s_tdata, s_tlast);
                if (row_typed)
                begin
                    while (pending_results.size() > depth)
                        void'(pending_results.pop_back());
                    pending_results.push_back(row_want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected output item: tdata %h tlast %b tuser %b",
                           m_tdata, m_tlast, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[7:0] !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b", want.byte_valid, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[8] !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, m_tdata[8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.string_end)
                    begin
                        $error("string_end: expected %b, got %b", want.string_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.truncated)
                    begin
                        $error("truncated: expected %b, got %b", want.truncated, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= out_stall_pct);
        else
            m_tready <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic drive_item(input logic [7:0] ch, input logic is_last,
                              input logic typed, input esc_result_t want);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= ch;
        s_tlast   <= is_last;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // limit changes only with the escaper drained
    task automatic set_limit(input logic [15:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // quiet margin before the register write
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        limit_model = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return CH_AMP;
        else if (roll < 16)
            return CH_LT;
        else if (roll < 24)
            return CH_GT;
        else if (roll < 32)
            return CH_QUOT;
        else if (roll < 42)
            return CH_LF;
        return 8'($urandom_range(255, 1));
    endfunction

    initial
    begin
        int          items_sent;
        int          phase;
        int          phase_items;
        int          str_len;
        int          ending;
        logic [15:0] lim;
        logic [7:0]  ch;

        // reset limit first, then limits of 1, 12 and 65534
        steps = '{
            '{ROW_ITEM,  16'h0000, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
            '{ROW_ITEM,  16'h00FF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0}},
            '{ROW_ITEM,  16'h0001, 1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_AMP),  1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_LT),   1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_GT),   1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_QUOT), 1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_LF),   1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h007A, 1'b1, 1'b1, '{8'h7A, 1'b1, 1'b1, 1'b1, 1'b0}},
            '{ROW_ITEM,  16'(CH_LF),   1'b1, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0000, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
            '{ROW_LIMIT, 16'd1,    1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0041, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0, 1'b1}},
            '{ROW_ITEM,  16'h0042, 1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0080, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
            '{ROW_ITEM,  16'(CH_AMP),  1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0000, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
            '{ROW_ITEM,  16'h007F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b1, 1'b1}},
            '{ROW_LIMIT, 16'd12,   1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_LF),   1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_LT),   1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0078, 1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0079, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
            '{ROW_LIMIT, 16'd65534, 1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'(CH_QUOT), 1'b1, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h0055, 1'b0, 1'b0, NO_RESULT},
            '{ROW_ITEM,  16'h00AA, 1'b1, 1'b0, NO_RESULT}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (steps[n])
        begin
            if (steps[n].kind == ROW_LIMIT)
                set_limit(steps[n].value);
            else
                drive_item(steps[n].value[7:0], steps[n].is_last, steps[n].typed,
                           steps[n].want);
        end

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0:       lim = 16'd1;
                1:       lim = 16'd65534;
                2:       lim = LIMIT_RESET;
                7:       lim = 16'($urandom_range(400, 41));
                8, 9:    lim = 16'($urandom_range(65534, 1));
                default: lim = 16'($urandom_range(40, 2));
            endcase
            set_limit(lim);
            // one phase in four runs with both streams flat out
            in_idle_pct   = (phase % 4 == 2) ? 0 : IDLE_PCT;
            out_stall_pct = (phase % 4 == 2) ? 0 : IDLE_PCT;
            phase_items = $urandom_range(50, 30);
            while (phase_items > 0)
            begin
                if ($urandom_range(7) == 0)
                begin
                    drive_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                               NO_RESULT);
                    phase_items--;
                    items_sent++;
                end
                str_len = $urandom_range(24, 1);
                ending = $urandom_range(19);
                for (int i = 0; i < str_len; i++)
                begin
                    ch = pick_char();
                    drive_item(ch, (ending < 15) && (i == str_len - 1), 1'b0, NO_RESULT);
                end
                phase_items -= str_len;
                items_sent += str_len;
                if (ending >= 15 && ending < 18)
                begin
                    drive_item(CH_NUL, 1'($urandom_range(1)), 1'b0, NO_RESULT);
                    phase_items--;
                    items_sent++;
                end
            end
            phase++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
